// File: rtl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared widths, reset values, register indexes, types and delta/clamp
// helpers for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int POS_WIDTH  = 12;
    localparam int LIM_WIDTH  = 12;
    localparam int CUR_WIDTH  = 12;
    localparam int BYTE_WIDTH = 8;
    localparam int DLT_WIDTH  = 10;
    localparam int CMP_WIDTH  = ((POS_WIDTH > LIM_WIDTH) ? POS_WIDTH : LIM_WIDTH) + 2;
    localparam int OUT_WIDTH  = 32;

    localparam logic [LIM_WIDTH-1:0] X_LIMIT_RST = LIM_WIDTH'(800 - 16);
    localparam logic [LIM_WIDTH-1:0] Y_LIMIT_RST = LIM_WIDTH'(600 - 24);
    localparam logic [POS_WIDTH-1:0] POS_X_RST   = POS_WIDTH'(400);
    localparam logic [POS_WIDTH-1:0] POS_Y_RST   = POS_WIDTH'(300);

    // header bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;
    localparam int HDR_X_OVF  = 6;
    localparam int HDR_Y_OVF  = 7;

    typedef enum logic [0:0] {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_HEADER = 3'b001,
        ST_XMOVE  = 3'b010,
        ST_YMOVE  = 3'b100
    } pkt_state_t;

    // collected packet bytes ahead of the y movement byte
    typedef struct packed {
        logic [BYTE_WIDTH-1:0] header;
        logic [BYTE_WIDTH-1:0] x_byte;
        logic                  last;
    } pkt_t;

    typedef struct packed {
        logic [CUR_WIDTH-1:0] cursor_x;
        logic [CUR_WIDTH-1:0] cursor_y;
    } move_t;

    // 9-bit two's complement delta, sign-extended to 10 bits, halved toward zero on overflow
    function automatic logic [DLT_WIDTH-1:0] make_delta(
        input logic                  sgn,
        input logic [BYTE_WIDTH-1:0] mag,
        input logic                  ovf
    );
        logic [DLT_WIDTH-1:0] d;
        logic [DLT_WIDTH-1:0] t;
        d = {sgn, sgn, mag};
        t = d + {{(DLT_WIDTH-1){1'b0}}, sgn};
        if (ovf) begin
            d = {t[DLT_WIDTH-1], t[DLT_WIDTH-1:1]};
        end
        return d;
    endfunction

    function automatic logic [POS_WIDTH-1:0] clamp_pos(
        input logic signed [CMP_WIDTH-1:0] v,
        input logic signed [CMP_WIDTH-1:0] lim
    );
        logic [POS_WIDTH-1:0] r;
        priority if (v <= 0) begin
            r = '0;
        end else if (v >= lim) begin
            r = lim[POS_WIDTH-1:0];
        end else begin
            r = v[POS_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic [CUR_WIDTH-1:0] to_cursor(input logic [POS_WIDTH-1:0] p);
        logic [CMP_WIDTH-1:0] w;
        w = {{(CMP_WIDTH-POS_WIDTH){1'b0}}, p};
        return w[CUR_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/ps2mct_assembler.sv
// ----------------------------------------------------------------------------
// ps2mct_assembler
// Collects the header and x movement bytes of each three-byte packet and
// tracks the position within the packet.
// ----------------------------------------------------------------------------
module ps2mct_assembler (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             byte_take,
    input  logic [ps2mct_pkg::BYTE_WIDTH-1:0] rx_byte,
    output ps2mct_pkg::pkt_t                 pkt
);
    import ps2mct_pkg::*;

    pkt_state_t            state_reg, state_next;
    logic [BYTE_WIDTH-1:0] header_reg, header_next;
    logic [BYTE_WIDTH-1:0] x_byte_reg, x_byte_next;

    always_comb begin
        state_next  = state_reg;
        header_next = header_reg;
        x_byte_next = x_byte_reg;
        if (byte_take) begin
            unique case (state_reg)
                ST_HEADER: begin
                    header_next = rx_byte;
                    state_next  = ST_XMOVE;
                end
                ST_XMOVE: begin
                    x_byte_next = rx_byte;
                    state_next  = ST_YMOVE;
                end
                default: begin
                    state_next = ST_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_HEADER;
            header_reg <= '0;
            x_byte_reg <= '0;
        end else begin
            state_reg  <= state_next;
            header_reg <= header_next;
            x_byte_reg <= x_byte_next;
        end
    end

    assign pkt.header = header_reg;
    assign pkt.x_byte = x_byte_reg;
    assign pkt.last   = (state_reg != ST_HEADER) && (state_reg != ST_XMOVE);

endmodule

// File: rtl/ps2mct_tracker.sv
// ----------------------------------------------------------------------------
// ps2mct_tracker
// Holds the cursor position and the limit registers; applies the packet
// deltas and clamps the new position.
// ----------------------------------------------------------------------------
module ps2mct_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  ps2mct_pkg::cfg_reg_t              cfg_sel,
    input  logic [ps2mct_pkg::LIM_WIDTH-1:0]  cfg_wdata,
    input  logic                              move_take,
    input  ps2mct_pkg::pkt_t                  pkt,
    input  logic [ps2mct_pkg::BYTE_WIDTH-1:0] y_byte,
    output ps2mct_pkg::move_t                 move
);
    import ps2mct_pkg::*;

    localparam logic [CMP_WIDTH-1:0] POS_MAX_EXT =
        {{(CMP_WIDTH-POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}};

    logic [LIM_WIDTH-1:0] x_limit_reg, x_limit_next;
    logic [LIM_WIDTH-1:0] y_limit_reg, y_limit_next;
    logic [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic [POS_WIDTH-1:0] pos_y_reg, pos_y_next;

    logic [DLT_WIDTH-1:0]        dx, dy;
    logic [CMP_WIDTH-1:0]        lim_x_ext, lim_y_ext;
    logic signed [CMP_WIDTH-1:0] lim_x, lim_y;
    logic signed [CMP_WIDTH-1:0] sum_x, sum_y;
    logic [POS_WIDTH-1:0]        new_x, new_y;

    always_comb begin
        x_limit_next = x_limit_reg;
        y_limit_next = y_limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_sel)
                REG_X_LIMIT: x_limit_next = cfg_wdata;
                REG_Y_LIMIT: y_limit_next = cfg_wdata;
            endcase
        end
    end

    assign dx = make_delta(pkt.header[HDR_X_SIGN], pkt.x_byte, pkt.header[HDR_X_OVF]);
    assign dy = make_delta(pkt.header[HDR_Y_SIGN], y_byte, pkt.header[HDR_Y_OVF]);

    // limits beyond the position range saturate at the largest position
    assign lim_x_ext = {{(CMP_WIDTH-LIM_WIDTH){1'b0}}, x_limit_reg};
    assign lim_y_ext = {{(CMP_WIDTH-LIM_WIDTH){1'b0}}, y_limit_reg};
    assign lim_x     = (lim_x_ext > POS_MAX_EXT) ? POS_MAX_EXT : lim_x_ext;
    assign lim_y     = (lim_y_ext > POS_MAX_EXT) ? POS_MAX_EXT : lim_y_ext;

    // screen y grows downward, mouse y grows upward
    assign sum_x = {{(CMP_WIDTH-POS_WIDTH){1'b0}}, pos_x_reg}
                 + {{(CMP_WIDTH-DLT_WIDTH){dx[DLT_WIDTH-1]}}, dx};
    assign sum_y = {{(CMP_WIDTH-POS_WIDTH){1'b0}}, pos_y_reg}
                 - {{(CMP_WIDTH-DLT_WIDTH){dy[DLT_WIDTH-1]}}, dy};

    assign new_x = clamp_pos(sum_x, lim_x);
    assign new_y = clamp_pos(sum_y, lim_y);

    assign pos_x_next = move_take ? new_x : pos_x_reg;
    assign pos_y_next = move_take ? new_y : pos_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
            pos_x_reg   <= POS_X_RST;
            pos_y_reg   <= POS_Y_RST;
        end else begin
            x_limit_reg <= x_limit_next;
            y_limit_reg <= y_limit_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
        end
    end

    assign move.cursor_x = to_cursor(new_x);
    assign move.cursor_y = to_cursor(new_y);

endmodule

// File: rtl/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// The result is registered and appears on m_tvalid in the cycle after the
// third byte of a packet is accepted. Throughput: one byte per cycle; the
// output register frees itself in the same cycle it is drained, so a packet
// end only stalls while an earlier result is held by m_tready low.
// Reset (aresetn low, synchronous): packet alignment to the header byte,
// cursor at 400/300, limits at 784/576, no pending result.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [ps2mct_pkg::LIM_WIDTH-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ps2mct_pkg::BYTE_WIDTH-1:0] s_tdata,   // [7:0] rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [24] left_pressed,
    // [25] right_pressed, [26] middle_pressed, [31:27] zero
    output logic [ps2mct_pkg::OUT_WIDTH-1:0]  m_tdata
);
    import ps2mct_pkg::*;

    pkt_t  pkt;
    move_t move;
    logic  byte_take;
    logic  move_take;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0] out_data_reg, out_data_next;

    // header and x bytes never need the output slot
    assign s_tready  = !pkt.last || !out_valid_reg || m_tready;
    assign byte_take = s_tvalid && s_tready;
    assign move_take = byte_take && pkt.last;

    ps2mct_assembler u_assembler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_take (byte_take),
        .rx_byte   (s_tdata),
        .pkt       (pkt)
    );

    ps2mct_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_sel   (cfg_reg_t'(cfg_index)),
        .cfg_wdata (cfg_wdata),
        .move_take (move_take),
        .pkt       (pkt),
        .y_byte    (s_tdata),
        .move      (move)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        priority if (move_take) begin
            out_valid_next = 1'b1;
            out_data_next  = {{(OUT_WIDTH - 2*CUR_WIDTH - 3){1'b0}},
                              pkt.header[HDR_MIDDLE],
                              pkt.header[HDR_RIGHT],
                              pkt.header[HDR_LEFT],
                              move.cursor_y,
                              move.cursor_x};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
